// ===== hw/rtl/ilsh_pkg.sv =====
`timescale 1ns / 1ps

// Shared types, widths and constants of the interrupt latency statistics block.
package ilsh_pkg;

   // Default sizes, handed to the top level parameters.
   localparam int ILSH_NUM_CPUS = 8;
   localparam int ILSH_NUM_BINS = 20;

   // Field widths of the ports.
   localparam int TS_W        = 64;
   localparam int IRQ_W       = 10;
   localparam int CPU_ID_W    = 3;
   localparam int NUM_CPU_IDS = 2 ** CPU_ID_W;
   localparam int STATUS_W    = 2;
   localparam int BIN_FIELD_W = 5;
   localparam int BIN_COUNT_W = 32;
   localparam int TARGET_W    = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   // Microsecond scaling: a shift takes out the factor 8 of the divisor, and
   // the remaining 125 is divided by a multiplication with a rounded-up
   // reciprocal, built from 32 by 32 bit partial products.
   localparam int US_DIVISOR   = 1000;
   localparam int DIV_PRESHIFT = 3;
   localparam int DIV_ODD      = US_DIVISOR >> DIV_PRESHIFT;
   localparam int DIV_X_W      = TS_W - DIV_PRESHIFT;
   localparam int DIV_SHIFT    = DIV_X_W + $clog2(DIV_ODD);
   localparam int DIV_MAGIC_W  = 62;
   localparam logic [127:0] DIV_MAGIC_WIDE =
      ((128'd1 << DIV_SHIFT) + 128'(DIV_ODD - 1)) / 128'(DIV_ODD);
   localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = DIV_MAGIC_W'(DIV_MAGIC_WIDE);
   localparam int MUL_W        = 32;
   localparam int DIV_TAIL     = DIV_SHIFT - 2 * MUL_W;
   localparam int DIV_STEPS    = 5;
   localparam int DIV_STEP_W   = $clog2(DIV_STEPS);

   // Leading-one search over the duration, in byte groups.
   localparam int GROUP_W     = 8;
   localparam int NUM_GROUPS  = TS_W / GROUP_W;
   localparam int GROUP_IDX_W = $clog2(NUM_GROUPS);
   localparam int GROUP_POS_W = $clog2(GROUP_W);
   localparam int LOG_W       = GROUP_IDX_W + GROUP_POS_W;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_FILTERED = 2'd0,
      STATUS_ENTRY    = 2'd1,
      STATUS_EXIT     = 2'd2,
      STATUS_UNKNOWN  = 2'd3
   } ilsh_status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FILTER_CGROUP  = 3'd0,
      REG_HISTOGRAM_MODE = 3'd1,
      REG_REPORT_NS      = 3'd2,
      REG_PER_CPU_KEYS   = 3'd3,
      REG_TARGET_CPU     = 3'd4,
      REG_LOCAL_IRQ      = 3'd5,
      REG_HRTIMER_IRQ    = 3'd6
   } ilsh_reg_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DELTA,
      ST_DIVIDE,
      ST_LOG_SCAN,
      ST_LOG_PICK,
      ST_HIST_READ,
      ST_UPDATE,
      ST_COMMIT
   } ilsh_state_type;

   // One statistics record.
   typedef struct packed {
      logic [TS_W-1:0] count;
      logic [TS_W-1:0] sum;
      logic [TS_W-1:0] peak;
   } ilsh_rec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic delta;
      logic div_start;
      logic log_scan;
      logic log_pick;
      logic hist_read;
      logic update;
      logic commit;
   } ilsh_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic req_is_exit;
      logic div_last;
      logic report_ns;
      logic hist_mode;
   } ilsh_stat_type;

   // Position of the highest set bit of one byte group, zero when empty.
   function automatic logic [GROUP_POS_W-1:0] group_msb(input logic [GROUP_W-1:0] v);
      logic [GROUP_POS_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < GROUP_W; i++) begin
         if (v[i]) begin
            pos = GROUP_POS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== hw/rtl/ilsh_div1000.sv =====
`timescale 1ns / 1ps

// Divides a 64-bit duration by the microsecond divisor: the dividend is shifted
// right by three, then multiplied by the rounded-up reciprocal of 125, one
// 32 by 32 bit partial product a cycle.
module ilsh_div1000
   import ilsh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [TS_W-1:0] dividend,
   output logic [TS_W-1:0] quotient,
   output logic            last
);

   logic [DIV_X_W-1:0]    num_ff;
   logic [2*MUL_W-1:0]    prod_ff;
   logic [2*MUL_W-1:0]    acc_ff, acc_in;
   logic [DIV_STEP_W-1:0] step_ff;
   logic                  busy_ff;
   logic [MUL_W-1:0]      mul_a;
   logic [MUL_W-1:0]      mul_b;

   assign last     = busy_ff && (step_ff == DIV_STEP_W'(DIV_STEPS - 1));
   assign quotient = acc_ff >> DIV_TAIL;

   // Operand halves: bit 1 of the step picks the upper half of the dividend,
   // bit 0 the upper half of the reciprocal.
   assign mul_a = step_ff[1] ? MUL_W'(num_ff[DIV_X_W-1:MUL_W]) : num_ff[MUL_W-1:0];
   assign mul_b = step_ff[0] ? MUL_W'(DIV_MAGIC[DIV_MAGIC_W-1:MUL_W]) :
                               DIV_MAGIC[MUL_W-1:0];

   // Accumulation of the previous partial product. The sum is kept shifted
   // down by 32 bits each time the weight of the products goes up, so that
   // after the last one it holds the product divided by 2 ** 64.
   always_comb begin
      if (step_ff == DIV_STEP_W'(1)) begin
         acc_in = prod_ff;
      end else if (step_ff[0]) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = (acc_ff >> MUL_W) + prod_ff;
      end
   end

   // Step counter and busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Shifted dividend, partial product and running sum.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend[TS_W-1:DIV_PRESHIFT];
      end else if (busy_ff) begin
         prod_ff <= mul_a * mul_b;
         if (step_ff != '0) begin
            acc_ff <= acc_in;
         end
      end
   end

endmodule

// ===== hw/rtl/ilsh_datapath.sv =====
`timescale 1ns / 1ps

// Configuration registers, start stamp, record and histogram memories, and the
// arithmetic of one event.
module ilsh_datapath
   import ilsh_pkg::*;
#(
   parameter int NUM_CPUS = ILSH_NUM_CPUS,
   parameter int NUM_BINS = ILSH_NUM_BINS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ilsh_cmd_type           cmd,
   output ilsh_stat_type          stat,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_mode,
   input  logic [IRQ_W-1:0]       req_irq_id,
   input  logic [CPU_ID_W-1:0]    req_cpu_id,
   input  logic [TS_W-1:0]        req_timestamp_ns,
   input  logic                   req_in_cgroup,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [TS_W-1:0]        rsp_duration,
   output logic [TS_W-1:0]        rsp_event_total,
   output logic [TS_W-1:0]        rsp_time_sum,
   output logic [TS_W-1:0]        rsp_time_peak,
   output logic [BIN_FIELD_W-1:0] rsp_bin_index,
   output logic [BIN_COUNT_W-1:0] rsp_bin_count
);

   localparam int NUM_RECS   = 2 * NUM_CPUS;
   localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int REC_W      = $clog2(NUM_RECS);
   localparam int HIST_DEPTH = NUM_RECS * NUM_BINS;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int BIN_W      = $clog2(NUM_BINS);

   // Configuration registers.
   logic                cfg_filter_cgroup_ff;
   logic                cfg_histogram_mode_ff;
   logic                cfg_report_ns_ff;
   logic                cfg_per_cpu_keys_ff;
   logic [TARGET_W-1:0] cfg_target_cpu_ff;
   logic [IRQ_W-1:0]    cfg_local_irq_ff;
   logic [IRQ_W-1:0]    cfg_hrtimer_irq_ff;

   // Captured event.
   ilsh_status_type     status_ff, status_in;
   logic [TS_W-1:0]     ts_ff;
   logic [REC_W-1:0]    slot_ff, slot_in;
   logic [REC_W-1:0]    rec_ff, rec_in;

   // Memories and their registered read data.
   logic [TS_W-1:0]        stamp_mem_ff [NUM_RECS];
   ilsh_rec_type           rec_mem_ff   [NUM_RECS];
   logic [BIN_COUNT_W-1:0] hist_mem_ff  [HIST_DEPTH];
   logic [TS_W-1:0]        stamp_rd_ff;
   ilsh_rec_type           rec_rd_ff;
   logic [BIN_COUNT_W-1:0] hist_rd_ff;

   // Clearing pass.
   logic [HIST_AW-1:0] clr_addr_ff;
   logic               clr_in_recs;

   // Duration and histogram working registers.
   logic [TS_W-1:0]        delta_ff, delta_in;
   logic [TS_W-1:0]        div_quot;
   logic [TS_W-1:0]        scaled;
   logic [NUM_GROUPS-1:0]  group_nz_ff;
   logic [GROUP_POS_W-1:0] group_pos_ff [NUM_GROUPS];
   logic [BIN_W-1:0]       bin_ff, bin_in;
   logic [HIST_AW-1:0]     haddr_ff, haddr_in;

   // Updated record values.
   logic [TS_W-1:0]        new_count_ff;
   logic [TS_W-1:0]        new_sum_ff;
   logic [TS_W-1:0]        new_peak_ff;
   logic [BIN_COUNT_W-1:0] new_bin_count_ff;

   // Output register.
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [TS_W-1:0]        rsp_duration_ff;
   logic [TS_W-1:0]        rsp_event_total_ff;
   logic [TS_W-1:0]        rsp_time_sum_ff;
   logic [TS_W-1:0]        rsp_time_peak_ff;
   logic [BIN_FIELD_W-1:0] rsp_bin_index_ff;
   logic [BIN_COUNT_W-1:0] rsp_bin_count_ff;

   // Memory write ports.
   logic                   stamp_we;
   logic [REC_W-1:0]       stamp_waddr;
   logic [TS_W-1:0]        stamp_wdata;
   logic                   rec_we;
   logic [REC_W-1:0]       rec_waddr;
   ilsh_rec_type           rec_wdata;
   logic                   hist_we;
   logic [HIST_AW-1:0]     hist_waddr;
   logic [BIN_COUNT_W-1:0] hist_wdata;

   logic                   is_exit;

   // CPU number to storage slot, worked out at elaboration.
   logic [CPU_W-1:0] slot_lut [NUM_CPU_IDS];
   logic [CPU_W-1:0] cpu_slot;

   for (genvar g = 0; g < NUM_CPU_IDS; g++) begin : g_slot_lut
      assign slot_lut[g] = CPU_W'(g % NUM_CPUS);
   end

   assign cpu_slot = slot_lut[req_cpu_id];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_filter_cgroup_ff  <= 1'b0;
         cfg_histogram_mode_ff <= 1'b0;
         cfg_report_ns_ff      <= 1'b0;
         cfg_per_cpu_keys_ff   <= 1'b0;
         cfg_target_cpu_ff     <= '1;
         cfg_local_irq_ff      <= IRQ_W'(0);
         cfg_hrtimer_irq_ff    <= IRQ_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FILTER_CGROUP:  cfg_filter_cgroup_ff  <= csr_data[0];
            REG_HISTOGRAM_MODE: cfg_histogram_mode_ff <= csr_data[0];
            REG_REPORT_NS:      cfg_report_ns_ff      <= csr_data[0];
            REG_PER_CPU_KEYS:   cfg_per_cpu_keys_ff   <= csr_data[0];
            REG_TARGET_CPU:     cfg_target_cpu_ff     <= csr_data[TARGET_W-1:0];
            REG_LOCAL_IRQ:      cfg_local_irq_ff      <= csr_data[IRQ_W-1:0];
            REG_HRTIMER_IRQ:    cfg_hrtimer_irq_ff    <= csr_data[IRQ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Classification of the offered event: filters first, then the timer kind.
   always_comb begin
      logic filtered;
      logic local_hit;
      logic hrtimer_hit;
      logic kind;
      logic [CPU_W-1:0] rec_cpu;
      filtered = (cfg_filter_cgroup_ff && !req_in_cgroup) ||
                 (!cfg_target_cpu_ff[TARGET_W-1] &&
                  (cfg_target_cpu_ff != {1'b0, req_cpu_id}));
      local_hit   = (req_irq_id == cfg_local_irq_ff);
      hrtimer_hit = (req_irq_id == cfg_hrtimer_irq_ff);
      // Equal id registers resolve to the local timer.
      kind = !local_hit;
      if (filtered) begin
         status_in = STATUS_FILTERED;
      end else if (!local_hit && !hrtimer_hit) begin
         status_in = STATUS_UNKNOWN;
      end else if (req_mode) begin
         status_in = STATUS_EXIT;
      end else begin
         status_in = STATUS_ENTRY;
      end
      rec_cpu = cfg_per_cpu_keys_ff ? cpu_slot : '0;
      slot_in = REC_W'({cpu_slot, kind});
      rec_in  = REC_W'({rec_cpu, kind});
   end

   assign stat.req_is_exit = (status_in == STATUS_EXIT);
   assign stat.report_ns   = cfg_report_ns_ff;
   assign stat.hist_mode   = cfg_histogram_mode_ff;

   // Event capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         status_ff <= status_in;
         ts_ff     <= req_timestamp_ns;
         slot_ff   <= slot_in;
         rec_ff    <= rec_in;
      end
   end

   assign is_exit = (status_ff == STATUS_EXIT);

   // Clearing pass over every store after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign clr_in_recs     = (clr_addr_ff < HIST_AW'(NUM_RECS));
   assign stat.clear_last = (clr_addr_ff == HIST_AW'(HIST_DEPTH - 1));

   // Start stamp memory: written by the clearing pass or an entry beat.
   assign stamp_we    = (cmd.clear && clr_in_recs) ||
                        (cmd.commit && (status_ff == STATUS_ENTRY));
   assign stamp_waddr = cmd.clear ? clr_addr_ff[REC_W-1:0] : slot_ff;
   assign stamp_wdata = cmd.clear ? '0 : ts_ff;

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem_ff[stamp_waddr] <= stamp_wdata;
      end
      if (cmd.capture) begin
         stamp_rd_ff <= stamp_mem_ff[slot_in];
      end
   end

   // Record memory: count, sum and peak of one record side by side.
   always_comb begin
      rec_wdata.count = new_count_ff;
      rec_wdata.sum   = cfg_histogram_mode_ff ? rec_rd_ff.sum  : new_sum_ff;
      rec_wdata.peak  = cfg_histogram_mode_ff ? rec_rd_ff.peak : new_peak_ff;
      if (cmd.clear) begin
         rec_wdata = '0;
      end
   end

   assign rec_we    = (cmd.clear && clr_in_recs) || (cmd.commit && is_exit);
   assign rec_waddr = cmd.clear ? clr_addr_ff[REC_W-1:0] : rec_ff;

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem_ff[rec_waddr] <= rec_wdata;
      end
      if (cmd.capture) begin
         rec_rd_ff <= rec_mem_ff[rec_in];
      end
   end

   // Raw duration, wrapping.
   assign delta_in = ts_ff - stamp_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.delta) begin
         delta_ff <= delta_in;
      end
   end

   ilsh_div1000 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (delta_in),
      .quotient (div_quot),
      .last     (stat.div_last)
   );

   assign scaled = cfg_report_ns_ff ? delta_ff : div_quot;

   // Leading-one search, first stage: one flag and one position per byte.
   always_ff @(posedge clock) begin
      if (cmd.log_scan) begin
         for (int b = 0; b < NUM_GROUPS; b++) begin
            group_nz_ff[b]  <= |scaled[b*GROUP_W +: GROUP_W];
            group_pos_ff[b] <= group_msb(scaled[b*GROUP_W +: GROUP_W]);
         end
      end
   end

   // Second stage: highest non-empty byte, then clamp to the last bin.
   always_comb begin
      logic [LOG_W-1:0] log_val;
      log_val = '0;
      for (int b = 0; b < NUM_GROUPS; b++) begin
         if (group_nz_ff[b]) begin
            log_val = {GROUP_IDX_W'(b), group_pos_ff[b]};
         end
      end
      if ({1'b0, log_val} >= (LOG_W + 1)'(NUM_BINS)) begin
         bin_in = BIN_W'(NUM_BINS - 1);
      end else begin
         bin_in = BIN_W'(log_val);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.log_pick) begin
         bin_ff <= bin_in;
      end
   end

   // Histogram memory: one row of bins for each record.
   assign haddr_in   = HIST_AW'(int'(rec_ff) * NUM_BINS + int'(bin_ff));
   assign hist_we    = cmd.clear || (cmd.commit && is_exit && cfg_histogram_mode_ff);
   assign hist_waddr = cmd.clear ? clr_addr_ff : haddr_ff;
   assign hist_wdata = cmd.clear ? '0 : new_bin_count_ff;

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem_ff[hist_waddr] <= hist_wdata;
      end
      if (cmd.hist_read) begin
         haddr_ff   <= haddr_in;
         hist_rd_ff <= hist_mem_ff[haddr_in];
      end
   end

   // Record update: counts and sums wrap.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         new_count_ff     <= rec_rd_ff.count + 1'b1;
         new_sum_ff       <= rec_rd_ff.sum + scaled;
         new_peak_ff      <= (scaled > rec_rd_ff.peak) ? scaled : rec_rd_ff.peak;
         new_bin_count_ff <= hist_rd_ff + 1'b1;
      end
   end

   // Result beat; fields that do not apply read as zero.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff      <= status_ff;
         rsp_duration_ff    <= is_exit ? scaled : '0;
         rsp_event_total_ff <= is_exit ? new_count_ff : '0;
         rsp_time_sum_ff    <= (is_exit && !cfg_histogram_mode_ff) ? new_sum_ff : '0;
         rsp_time_peak_ff   <= (is_exit && !cfg_histogram_mode_ff) ? new_peak_ff : '0;
         rsp_bin_index_ff   <= (is_exit && cfg_histogram_mode_ff) ?
                               BIN_FIELD_W'(bin_ff) : '0;
         rsp_bin_count_ff   <= (is_exit && cfg_histogram_mode_ff) ?
                               new_bin_count_ff : '0;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_duration    = rsp_duration_ff;
   assign rsp_event_total = rsp_event_total_ff;
   assign rsp_time_sum    = rsp_time_sum_ff;
   assign rsp_time_peak   = rsp_time_peak_ff;
   assign rsp_bin_index   = rsp_bin_index_ff;
   assign rsp_bin_count   = rsp_bin_count_ff;

endmodule

// ===== hw/rtl/ilsh_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer of one event: clearing pass, capture, duration, optional divide and
// bin search, record update and result beat.
module ilsh_ctrl
   import ilsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ilsh_stat_type stat,
   output ilsh_cmd_type  cmd
);

   ilsh_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The output register takes a new beat once the previous one is gone.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_is_exit ? ST_DELTA : ST_COMMIT;
            end
         end
         ST_DELTA: begin
            if (!stat.report_ns) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = stat.hist_mode ? ST_LOG_SCAN : ST_UPDATE;
            end
         end
         ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = stat.hist_mode ? ST_LOG_SCAN : ST_UPDATE;
            end
         end
         ST_LOG_SCAN:  state_in = ST_LOG_PICK;
         ST_LOG_PICK:  state_in = ST_HIST_READ;
         ST_HIST_READ: state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      cmd.clear     = (state_ff == ST_CLEAR);
      cmd.delta     = (state_ff == ST_DELTA);
      cmd.div_start = (state_ff == ST_DELTA) && !stat.report_ns;
      cmd.log_scan  = (state_ff == ST_LOG_SCAN);
      cmd.log_pick  = (state_ff == ST_LOG_PICK);
      cmd.hist_read = (state_ff == ST_HIST_READ);
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.commit    = (state_ff == ST_COMMIT) && out_free;
      if (state_ff == ST_IDLE) begin
         req_ready   = 1'b1;
         cmd.capture = req_valid;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // State and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/irq_latency_stats_histogram_unit.sv =====
`timescale 1ns / 1ps

// Timer interrupt latency statistics. Each request beat is a handler entry or
// exit event; each one gives exactly one response beat with its status. Entry
// events store their timestamp per CPU and timer kind, exit events take the
// wrapping difference to that stamp, scale it to microseconds unless
// nanoseconds are selected, and update either the total and maximum or a
// floor-log2 histogram bin of the record chosen by kind (and CPU when per-CPU
// keys are on). Events are handled one at a time. An entry, a filtered event or
// an unknown id goes from accept straight to the result beat; an exit passes
// through the duration step, the divide-by-1000 unit in microsecond mode,
// which multiplies by a reciprocal one 32 by 32 bit partial product a cycle,
// the histogram bin search and memory read in histogram mode, and the record
// update. A result still waiting in the output register only holds the block
// at the point where the next result is written. After reset a clearing pass
// zeroes the histogram memory, one bin per cycle, together with the stamp and
// record memories; no event is accepted during it, while configuration writes
// are always taken.
module irq_latency_stats_histogram_unit
   import ilsh_pkg::*;
#(
   parameter int NUM_CPUS = ILSH_NUM_CPUS,
   parameter int NUM_BINS = ILSH_NUM_BINS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [IRQ_W-1:0]       req_irq_id,
   input  logic [CPU_ID_W-1:0]    req_cpu_id,
   input  logic [TS_W-1:0]        req_timestamp_ns,
   input  logic                   req_in_cgroup,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [TS_W-1:0]        rsp_duration,
   output logic [TS_W-1:0]        rsp_event_total,
   output logic [TS_W-1:0]        rsp_time_sum,
   output logic [TS_W-1:0]        rsp_time_peak,
   output logic [BIN_FIELD_W-1:0] rsp_bin_index,
   output logic [BIN_COUNT_W-1:0] rsp_bin_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ilsh_cmd_type  cmd;
   ilsh_stat_type stat;

   // Registers are writable in every cycle.
   assign csr_ready = 1'b1;

   ilsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ilsh_datapath #(
      .NUM_CPUS (NUM_CPUS),
      .NUM_BINS (NUM_BINS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_mode         (req_mode),
      .req_irq_id       (req_irq_id),
      .req_cpu_id       (req_cpu_id),
      .req_timestamp_ns (req_timestamp_ns),
      .req_in_cgroup    (req_in_cgroup),
      .rsp_status       (rsp_status),
      .rsp_duration     (rsp_duration),
      .rsp_event_total  (rsp_event_total),
      .rsp_time_sum     (rsp_time_sum),
      .rsp_time_peak    (rsp_time_peak),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bin_count    (rsp_bin_count)
   );

endmodule

// ===== hw/rtl/ilsh_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks of the latency statistics block.
module ilsh_checker
   import ilsh_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic [TS_W-1:0]        rsp_duration,
   input logic [TS_W-1:0]        rsp_event_total,
   input logic [TS_W-1:0]        rsp_time_sum,
   input logic [TS_W-1:0]        rsp_time_peak,
   input logic [BIN_FIELD_W-1:0] rsp_bin_index,
   input logic [BIN_COUNT_W-1:0] rsp_bin_count
);

   // No result beat is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled result beat holds its status, duration and event total.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_duration) && $stable(rsp_event_total))
      else $error("stalled result changed");

   // One event at a time: an accepted beat closes the request side.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second event taken while one is in flight");

   // Only exit beats carry statistics.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_EXIT) |->
         (rsp_duration == '0) && (rsp_event_total == '0) &&
         (rsp_time_sum == '0) && (rsp_bin_count == '0))
      else $error("statistics on a non-exit result");

   // An exit count is never zero, and totals and histogram fields are never reported together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EXIT) |->
         (rsp_event_total != '0) &&
         (((rsp_time_sum == '0) && (rsp_time_peak == '0)) ||
          ((rsp_bin_index == '0) && (rsp_bin_count == '0))))
      else $error("exit result mixes totals and histogram");

endmodule

bind irq_latency_stats_histogram_unit ilsh_checker u_checker (.*);
